[src/sct_pkg.sv]
// ----------------------------------------------------------------------------
// sct_pkg
// Types and constants shared by the suspect counter table modules.
// ----------------------------------------------------------------------------
package sct_pkg;

  localparam int unsigned TableDepthDefault = 64;

  localparam logic       CmdObserve = 1'b0;
  localparam logic       CmdAge     = 1'b1;
  localparam logic [1:0] KindNone   = 2'h0;
  localparam logic [1:0] KindAddr   = 2'h1;
  localparam logic [1:0] KindPort   = 2'h2;
  localparam logic [1:0] KindBoth   = 2'h3;

  typedef struct packed {
    logic        command;
    logic [1:0]  kind;
    logic [31:0] ip_addr;
    logic [15:0] port_number;
    logic [7:0]  threshold;
  } sct_in_t;

  typedef struct packed {
    logic       danger;
    logic       inserted;
    logic       dropped;
    logic [6:0] occupancy;
  } sct_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_HIT,
    ST_AGE,
    ST_DONE
  } sct_state_e;

  // Controller to datapath.
  typedef struct packed {
    logic load;       // capture item, reset scan pointers
    logic scan_step;  // compare entry at read pointer, advance
    logic hit_write;  // write updated count at the matched entry
    logic age_step;   // age one entry and compact
    logic finish;     // append/drop decision and result
  } sct_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic is_age;
    logic is_nop;
    logic scan_end;  // read pointer reached entry total
    logic matched;   // compare in this scan step hit
  } sct_sts_t;

endpackage

[src/sct_ctrl.sv]
// ----------------------------------------------------------------------------
// sct_ctrl
// Sequencer: at most one scan over the stored entries per item.
// ----------------------------------------------------------------------------
module sct_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  sct_pkg::sct_sts_t sts_i,
  output sct_pkg::sct_cmd_t cmd_o,
  output logic              busy_o
);

  sct_pkg::sct_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= sct_pkg::ST_IDLE;
    else         state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy_o  = 1'b1;
    unique case (state_q)
      sct_pkg::ST_IDLE: begin
        busy_o = 1'b0;
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = sct_pkg::ST_SCAN;
        end
      end
      sct_pkg::ST_SCAN: begin
        if (sts_i.is_age) begin
          state_d = sct_pkg::ST_AGE;
        end else if (sts_i.is_nop || sts_i.scan_end) begin
          state_d = sct_pkg::ST_DONE;
        end else begin
          cmd_o.scan_step = 1'b1;
          if (sts_i.matched) state_d = sct_pkg::ST_HIT;
        end
      end
      sct_pkg::ST_HIT: begin
        cmd_o.hit_write = 1'b1;
        state_d         = sct_pkg::ST_DONE;
      end
      sct_pkg::ST_AGE: begin
        if (sts_i.scan_end) state_d = sct_pkg::ST_DONE;
        else                cmd_o.age_step = 1'b1;
      end
      sct_pkg::ST_DONE: begin
        cmd_o.finish = 1'b1;
        state_d      = sct_pkg::ST_IDLE;
      end
      default: state_d = sct_pkg::ST_IDLE;
    endcase
  end

endmodule

[src/sct_dp.sv]
// ----------------------------------------------------------------------------
// sct_dp
// Entry store, key compare, count update and in-place compaction.
// ----------------------------------------------------------------------------
module sct_dp #(
  parameter int unsigned TableDepth = sct_pkg::TableDepthDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sct_pkg::sct_in_t  item_i,
  input  sct_pkg::sct_cmd_t cmd_i,
  output sct_pkg::sct_sts_t sts_o,
  output logic              res_valid_o,
  output sct_pkg::sct_out_t res_o
);

  localparam int unsigned IdxW = (TableDepth > 1) ? $clog2(TableDepth) : 1;
  localparam int unsigned CntW = $clog2(TableDepth + 1);
  localparam logic [CntW-1:0] Full = CntW'(TableDepth);

  // Entry word: kind, ip, port, count.
  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] ip;
    logic [15:0] port;
    logic [7:0]  count;
  } entry_t;

  entry_t mem [TableDepth];

  sct_pkg::sct_in_t item_q;
  logic [CntW-1:0]  total_q;
  logic [CntW-1:0]  rd_q;    // scan/read pointer
  logic [CntW-1:0]  wr_q;    // compaction write pointer
  logic [IdxW-1:0]  hit_q;
  logic [7:0]       hit_cnt_q;
  entry_t           rdat_q;  // registered read, holds mem[rd_q]
  logic [CntW-1:0]  rd_nxt;
  logic             res_hit_q;

  // Read address follows the next pointer so the data lines up with rd_q.
  always_comb begin
    rd_nxt = rd_q;
    if (cmd_i.load) rd_nxt = '0;
    else if (cmd_i.scan_step || cmd_i.age_step) rd_nxt = rd_q + CntW'(1);
  end

  logic [31:0] key_ip;
  logic [15:0] key_port;
  assign key_ip   = (item_q.kind == sct_pkg::KindPort) ? 32'h0 : item_q.ip_addr;
  assign key_port = (item_q.kind == sct_pkg::KindAddr) ? 16'h0 : item_q.port_number;

  logic ip_eq, port_eq, match;
  assign ip_eq   = rdat_q.ip == key_ip;
  assign port_eq = rdat_q.port == key_port;
  always_comb begin
    unique case (rdat_q.kind)
      sct_pkg::KindAddr: match = ip_eq;
      sct_pkg::KindPort: match = port_eq;
      sct_pkg::KindBoth: match = ip_eq && port_eq;
      default:           match = 1'b0;
    endcase
  end

  // Hit count update: add one, hold the old count once past threshold.
  logic [8:0] inc;
  logic [7:0] new_cnt;
  logic       hit_danger;
  assign inc        = {1'b0, hit_cnt_q} + 9'd1;
  assign hit_danger = inc >= {1'b0, item_q.threshold};
  assign new_cnt    = (inc > {1'b0, item_q.threshold}) ? hit_cnt_q : inc[7:0];

  logic [7:0] aged;
  assign aged = (rdat_q.count != 8'd0) ? rdat_q.count - 8'd1 : 8'd0;

  assign sts_o.is_age   = item_q.command == sct_pkg::CmdAge;
  assign sts_o.is_nop   = item_q.kind == sct_pkg::KindNone;
  assign sts_o.scan_end = rd_q >= total_q;
  assign sts_o.matched  = match;

  logic danger_q;

  always_ff @(posedge clk_i) begin
    rdat_q <= mem[rd_nxt[IdxW-1:0]];
    if (cmd_i.load) item_q <= item_i;
    if (cmd_i.scan_step && match) begin
      hit_q     <= rd_q[IdxW-1:0];
      hit_cnt_q <= rdat_q.count;
    end
    if (cmd_i.hit_write) mem[hit_q].count <= new_cnt;
    if (cmd_i.age_step && aged != 8'd0)
      mem[wr_q[IdxW-1:0]] <= '{kind: rdat_q.kind, ip: rdat_q.ip, port: rdat_q.port,
                               count: aged};
    if (cmd_i.finish && !sts_o.is_age && !sts_o.is_nop && !danger_q && total_q < Full &&
        !res_hit_q)
      mem[total_q[IdxW-1:0]] <= '{kind: item_q.kind, ip: key_ip, port: key_port, count: 8'd0};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q     <= '0;
      rd_q        <= '0;
      wr_q        <= '0;
      danger_q    <= 1'b0;
      res_hit_q   <= 1'b0;
      res_valid_o <= 1'b0;
      res_o       <= '0;
    end else begin
      res_valid_o <= 1'b0;
      if (cmd_i.load) begin
        rd_q      <= '0;
        wr_q      <= '0;
        danger_q  <= 1'b0;
        res_hit_q <= 1'b0;
      end
      if (cmd_i.scan_step) begin
        rd_q <= rd_q + CntW'(1);
        if (match) res_hit_q <= 1'b1;
      end
      if (cmd_i.hit_write) danger_q <= hit_danger;
      if (cmd_i.age_step) begin
        rd_q <= rd_q + CntW'(1);
        if (aged != 8'd0) wr_q <= wr_q + CntW'(1);
      end
      if (cmd_i.finish) begin
        res_valid_o <= 1'b1;
        res_o       <= '0;
        if (sts_o.is_age) begin
          total_q         <= wr_q;
          res_o.occupancy <= 7'(wr_q);
        end else if (sts_o.is_nop || res_hit_q) begin
          res_o.danger    <= danger_q;
          res_o.occupancy <= 7'(total_q);
        end else if (total_q < Full) begin
          total_q         <= total_q + CntW'(1);
          res_o.inserted  <= 1'b1;
          res_o.occupancy <= 7'(total_q + CntW'(1));
        end else begin
          res_o.dropped   <= 1'b1;
          res_o.occupancy <= 7'(total_q);
        end
      end
    end
  end

endmodule

[src/suspect_counter_table_top.sv]
// ----------------------------------------------------------------------------
// suspect_counter_table_top
// Ordered suspect key table with saturating per-key counters.
// ----------------------------------------------------------------------------
//  channel | signals                    | transfer
//  input   | start_i, busy_o, item_i    | start_i && !busy_o
//  result  | done_o, result_o           | done_o (one cycle, no stall)
//
// Observe: k entries scanned up to the first match (at most the entry
// total); age: the whole entry total, one entry per cycle through the
// single registered store read port. Reset empties the table at once.
// Results cannot be stalled; busy_o stays high until the result is shown.
module suspect_counter_table_top #(
  parameter int unsigned TableDepth = sct_pkg::TableDepthDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  sct_pkg::sct_in_t item_i,
  output logic             busy_o,
  output logic             done_o,
  output sct_pkg::sct_out_t result_o
);

  sct_pkg::sct_cmd_t cmd;
  sct_pkg::sct_sts_t sts;

  sct_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .sts_i  (sts),
    .cmd_o  (cmd),
    .busy_o (busy_o)
  );

  sct_dp #(.TableDepth(TableDepth)) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .item_i     (item_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .res_valid_o(done_o),
    .res_o      (result_o)
  );

endmodule
